// ===== src/tcit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcit_pkg;

  localparam int NumCounters = 3;

  // Request codes.
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_GATE  = 2'd3;

  localparam logic [1:0] CTRL_PORT = 2'd3;

  // Read/write access field of a control word.
  localparam logic [1:0] RW_LATCH = 2'd0;
  localparam logic [1:0] RW_LSB   = 2'd1;
  localparam logic [1:0] RW_MSB   = 2'd2;
  localparam logic [1:0] RW_WORD  = 2'd3;

  // Byte sequencing phases.
  localparam logic [1:0] PH_READY = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  localparam logic [2:0] MODE_0 = 3'd0;
  localparam logic [2:0] MODE_1 = 3'd1;
  localparam logic [2:0] MODE_2 = 3'd2;
  localparam logic [2:0] MODE_5 = 3'd5;
  localparam logic [2:0] MODE_6 = 3'd6;

  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [2:0] OUT_ENABLE_RESET = 3'd3;
  localparam logic [2:0] GATE_RESET = 3'b011;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       ctrl;
    logic       tick;
    logic       gate;
    logic [7:0] wdata;
    logic       level;
  } tcit_req_t;

  // One step down, with each decimal digit that wrapped to F pulled back to 9.
  function automatic logic [15:0] count_down(input logic [15:0] c, input logic bcd);
    logic [15:0] d;
    d = c - 16'd1;
    if (bcd) begin
      if (d[3:0] == 4'hF) d[3:0] = 4'h9;
      if (d[7:4] == 4'hF) d[7:4] = 4'h9;
      if (d[11:8] == 4'hF) d[11:8] = 4'h9;
      if (d[15:12] == 4'hF) d[15:12] = 4'h9;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/tcit_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcit_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] port;
  logic [7:0] wdata;
  logic       gate_level;

  modport source (output valid, output req_type, output port, output wdata,
                  output gate_level, input ready);
  modport sink (input valid, input req_type, input port, input wdata,
                input gate_level, output ready);
endinterface

interface tcit_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic [2:0] fire_mask;

  modport source (output valid, output rdata, output fire_mask, input ready);
  modport sink (input valid, input rdata, input fire_mask, output ready);
endinterface

`default_nettype wire

// ===== src/tcit_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcit_counter
  import tcit_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       gate_init,
  input  wire tcit_req_t  req,
  output logic      [7:0] rdata,
  output logic            fire
);

  logic [7:0]  cw_r, cw_nxt;
  logic [15:0] iv_r, iv_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] lat_r, lat_nxt;
  logic        run_r, run_nxt;
  logic        lh_r, lh_nxt;
  logic [1:0]  rp_r, rp_nxt;
  logic [1:0]  wp_r, wp_nxt;
  logic        gate_r, gate_nxt;

  logic [2:0]  mode;
  logic [1:0]  rw;
  logic        gated;
  logic        wr_load;
  logic [15:0] dec;
  logic        hit;

  assign mode  = cw_r[3:1];
  assign rw    = cw_r[5:4];
  assign gated = !(mode == MODE_1 || mode == MODE_5);
  assign dec   = count_down(cnt_r, cw_r[0]);
  assign hit   = (mode == MODE_2 || mode == MODE_6) ? (dec == 16'd1) : (dec == 16'd0);

  always_comb begin
    cw_nxt   = cw_r;
    iv_nxt   = iv_r;
    cnt_nxt  = cnt_r;
    lat_nxt  = lat_r;
    run_nxt  = run_r;
    lh_nxt   = lh_r;
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    gate_nxt = gate_r;
    rdata    = IDLE_BYTE;
    fire     = 1'b0;
    wr_load  = 1'b0;

    if (req.rd) begin
      if (lh_r) begin
        if (rp_r == PH_HIGH) begin
          rdata  = lat_r[15:8];
          rp_nxt = PH_READY;
          lh_nxt = 1'b0;
        end else begin
          rdata  = lat_r[7:0];
          rp_nxt = PH_HIGH;
        end
      end else begin
        case (rw)
          RW_LSB: begin
            rdata  = cnt_r[7:0];
            rp_nxt = PH_READY;
          end
          RW_MSB: begin
            rdata  = cnt_r[15:8];
            rp_nxt = PH_READY;
          end
          RW_WORD: begin
            if (rp_r == PH_HIGH) begin
              rdata  = cnt_r[15:8];
              rp_nxt = PH_READY;
            end else begin
              rdata  = cnt_r[7:0];
              rp_nxt = PH_HIGH;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (req.wr) begin
      case (rw)
        RW_LSB: begin
          iv_nxt  = {8'h00, req.wdata};
          wp_nxt  = PH_READY;
          wr_load = 1'b1;
        end
        RW_MSB: begin
          iv_nxt  = {req.wdata, 8'h00};
          wp_nxt  = PH_READY;
          wr_load = 1'b1;
        end
        RW_WORD: begin
          if (wp_r == PH_HIGH) begin
            iv_nxt = {req.wdata, iv_r[7:0]};
            wp_nxt = PH_READY;
          end else begin
            iv_nxt = {8'h00, req.wdata};
            wp_nxt = PH_HIGH;
          end
          wr_load = 1'b1;
        end
        default: begin
        end
      endcase
      // A running counter in a retriggerable or gated mode keeps its count
      // until the next reload point; mode 0 always restarts.
      if (wr_load && wp_nxt == PH_READY &&
          (mode == MODE_0 || (gated && !run_r))) begin
        cnt_nxt = iv_nxt;
        run_nxt = 1'b1;
      end
    end else if (req.ctrl) begin
      lh_nxt = 1'b0;
      if (req.wdata[5:4] == RW_LATCH) begin
        lh_nxt  = 1'b1;
        lat_nxt = cnt_r;
        rp_nxt  = PH_LOW;
        fire    = (mode != MODE_0);
      end else begin
        cw_nxt  = req.wdata;
        run_nxt = 1'b0;
        rp_nxt  = (req.wdata[5:4] == RW_MSB) ? PH_HIGH : PH_LOW;
        wp_nxt  = (req.wdata[5:4] == RW_MSB) ? PH_HIGH : PH_LOW;
        fire    = (req.wdata[3:1] != MODE_0);
      end
    end else if (req.tick) begin
      if (run_r && (!gated || gate_r)) begin
        cnt_nxt = dec;
        if (hit) begin
          fire = 1'b1;
          // Modes 2, 3, 6 and 7 reload unless a word write is half done; the others stop.
          if (mode[1]) begin
            if (wp_r == PH_READY) begin
              cnt_nxt = iv_r;
              run_nxt = 1'b1;
            end
          end else begin
            run_nxt = 1'b0;
          end
        end
      end
    end else if (req.gate) begin
      if (mode != MODE_0 && !gate_r && req.level && wp_r == PH_READY) begin
        cnt_nxt = iv_r;
        run_nxt = 1'b1;
      end
      gate_nxt = req.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r   <= 8'h00;
      iv_r   <= 16'h0000;
      cnt_r  <= 16'h0000;
      lat_r  <= 16'h0000;
      run_r  <= 1'b0;
      lh_r   <= 1'b0;
      rp_r   <= PH_READY;
      wp_r   <= PH_READY;
      gate_r <= gate_init;
    end else begin
      cw_r   <= cw_nxt;
      iv_r   <= iv_nxt;
      cnt_r  <= cnt_nxt;
      lat_r  <= lat_nxt;
      run_r  <= run_nxt;
      lh_r   <= lh_nxt;
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      gate_r <= gate_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/three_channel_interval_timer_top.sv =====
// Flow: an accepted item waits in the input register, and its result is captured in the result register
// when the item advances, and can be taken from there; a stall on out_ch holds it in the input register.
// Throughput: one item per cycle while out_ch takes results; the input register and the result register
// form a two-stage pipeline and all counter updates are combinational between them.
// Reset: synchronous active-low rst_n clears the pipeline and all counters;
// gates of counters 0 and 1 come up high, counter 2 low, out_enable is 3.
`timescale 1ns / 1ps
`default_nettype none

module three_channel_interval_timer_top
  import tcit_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  tcit_in_if.sink         in_ch,
  tcit_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata
);

  logic       in_valid_r;
  logic [1:0] req_type_r;
  logic [1:0] port_r;
  logic [7:0] wdata_r;
  logic       level_r;

  logic       out_valid_r;
  logic [7:0] rdata_r;
  logic [2:0] fire_r;
  logic [2:0] out_enable_r;

  logic       adv;
  logic [7:0] cnt_rdata [NumCounters];
  logic [2:0] cnt_fire;
  logic [7:0] rdata_sel;

  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.rdata = rdata_r;
  assign out_ch.fire_mask = fire_r;

  for (genvar i = 0; i < NumCounters; i++) begin : g_cnt
    tcit_req_t req;
    logic      sel;

    assign sel = (port_r == 2'(i));
    assign req.rd    = adv && req_type_r == REQ_READ && sel;
    assign req.wr    = adv && req_type_r == REQ_WRITE && sel;
    assign req.ctrl  = adv && req_type_r == REQ_WRITE && port_r == CTRL_PORT &&
                       wdata_r[7:6] == 2'(i);
    assign req.tick  = adv && req_type_r == REQ_TICK;
    assign req.gate  = adv && req_type_r == REQ_GATE && sel;
    assign req.wdata = wdata_r;
    assign req.level = level_r;

    tcit_counter u_counter (
      .clk       (clk),
      .rst_n     (rst_n),
      .gate_init (GATE_RESET[i]),
      .req       (req),
      .rdata     (cnt_rdata[i]),
      .fire      (cnt_fire[i])
    );
  end

  always_comb begin
    case (port_r)
      2'd0:    rdata_sel = cnt_rdata[0];
      2'd1:    rdata_sel = cnt_rdata[1];
      2'd2:    rdata_sel = cnt_rdata[2];
      default: rdata_sel = IDLE_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      out_enable_r <= OUT_ENABLE_RESET;
    end else begin
      if (cfg_we) begin
        out_enable_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_type_r <= in_ch.req_type;
      port_r     <= in_ch.port;
      wdata_r    <= in_ch.wdata;
      level_r    <= in_ch.gate_level;
    end
    if (adv) begin
      rdata_r <= (req_type_r == REQ_READ) ? rdata_sel : IDLE_BYTE;
      fire_r  <= cnt_fire & out_enable_r;
    end
  end

endmodule

`default_nettype wire
